/* sv/ssdm_pkg.sv */
package ssdm_pkg;

   localparam int FRAC_BITS_DEF = 14;

   // configuration register indexes
   localparam logic [1:0] CSR_JOY_CENTER = 2'd0;
   localparam logic [1:0] CSR_THR_DZ     = 2'd1;
   localparam logic [1:0] CSR_STR_DZ     = 2'd2;

   localparam logic [9:0]  JOY_CENTER_RST = 10'd195;
   localparam logic [14:0] THR_DZ_RST     = 15'd2621;
   localparam logic [14:0] STR_DZ_RST     = 15'd1638;

   typedef struct packed {
      logic [9:0]  throttle_count;
      logic [9:0]  steer_count;
      logic [7:0]  tilt_deg;
      logic [12:0] front_mv;
      logic [12:0] rear_mv;
   } req_type;

   typedef struct packed {
      logic [7:0] left_speed;
      logic [7:0] right_speed;
      logic       left_forward;
      logic       right_forward;
   } rsp_type;

endpackage

/* sv/ssdm_mul.sv */
// shift-add multiplier: one multiplier bit per cycle, stops after the top set bit,
// gives the low W bits of the product
module ssdm_mul #(
   parameter int W = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         done,
   output logic [W-1:0] product
);
   localparam int CW = $clog2(W + 1);

   logic [2*W-1:0] acc_ff, acc_in;
   logic [2*W-1:0] mcand_ff, mcand_in;
   logic [W-1:0]   mplier_ff, mplier_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   // one partial product per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = {{W{1'b0}}, a};
         mplier_in = b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1) || mplier_ff[W-1:1] == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[W-1:0];
endmodule

/* sv/ssdm_div.sv */
// restoring divider: one quotient bit per cycle
module ssdm_div #(
   parameter int W = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quot
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[W-1]};
      if (start) begin
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

/* sv/skid_steer_drive_mixer_core.sv */
// result: built by five bit-serial quotients and up to seven shift-add products (W = FRAC_BITS+26),
// each product stopping after the multiplier's top set bit
// throughput: one transaction at a time; the next is taken once the sequencer is idle
// reset: synchronous, active high; configuration registers return to their defaults, directions reverse
module skid_steer_drive_mixer_core #(
   parameter int FRAC_BITS = ssdm_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssdm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ssdm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [14:0]       csr_wdata
);
   localparam int W = FRAC_BITS + 26;
   localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
   localparam logic [W-1:0] HALF = ONE >> 1;
   localparam logic [W-1:0] FLOOR = W'((4 * (64'd1 << FRAC_BITS) + 5) / 10);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_T, S_DIV_S, S_DIV_TILT, S_DIV_F, S_DIV_R,
      S_MIX, S_SCALE_L1, S_SCALE_L2, S_SCALE_L3, S_SCALE_R1, S_SCALE_R2,
      S_SCALE_R3, S_DONE
   } state_type;

   state_type state_ff;
   logic [9:0]  center_ff;
   logic [14:0] tdz_ff, sdz_ff;
   ssdm_pkg::req_type req_ff;
   logic [W-1:0] t_mag_ff, s_mag_ff, tilt_ff, front_ff, rear_ff;
   logic [W-1:0] left_ff, right_ff;
   logic         t_neg_ff, t_zero_ff, s_neg_ff, s_zero_ff, near_f_ff, near_r_ff;
   logic [1:0]   dir_ff;
   logic         rsp_valid_ff;
   ssdm_pkg::rsp_type rsp_ff;

   logic         div_start, mul_start, div_done, mul_done;
   logic [W-1:0] div_num, div_den, div_q, mul_a, mul_b, mul_p;

   ssdm_div #(.W(W)) u_div (.clock, .reset, .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_q));
   ssdm_mul #(.W(W)) u_mul (.clock, .reset, .start(mul_start), .a(mul_a),
      .b(mul_b), .done(mul_done), .product(mul_p));

   // axis shaping front end
   logic signed [10:0] dt, ds;
   logic [9:0]  mt, ms;
   logic        dzt, dzs, sat_t, sat_s;
   logic [7:0]  tilt_a;
   logic [12:0] fv, rv;
   assign dt = $signed({1'b0, req_ff.throttle_count}) - $signed({1'b0, center_ff});
   assign ds = $signed({1'b0, req_ff.steer_count}) - $signed({1'b0, center_ff});
   assign mt = dt[10] ? 10'(-dt) : dt[9:0];
   assign ms = ds[10] ? 10'(-ds) : ds[9:0];
   assign dzt = (W'(mt) << FRAC_BITS) < W'(tdz_ff) * W'(26);
   assign dzs = (W'(ms) << FRAC_BITS) < W'(sdz_ff) * W'(25);
   assign sat_t = mt > 10'd26;
   assign sat_s = ms > 10'd25;
   assign tilt_a = (req_ff.tilt_deg > 8'd90) ? 8'd90 :
                   (req_ff.tilt_deg <= 8'd10) ? 8'd0 : req_ff.tilt_deg;
   assign fv = (req_ff.front_mv < 13'd500) ? 13'd0 : req_ff.front_mv;
   assign rv = (req_ff.rear_mv < 13'd500) ? 13'd0 : req_ff.rear_mv;

   // unit operand selection
   always_comb begin
      div_num = '0;
      div_den = W'(26);
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         S_DIV_T:    begin div_num = W'(mt) << FRAC_BITS; div_den = W'(26); end
         S_DIV_S:    begin div_num = W'(ms) << FRAC_BITS; div_den = W'(25); end
         S_DIV_TILT: begin div_num = W'(8'd90 - tilt_a) << FRAC_BITS; div_den = W'(90); end
         S_DIV_F:    begin div_num = W'(13'd4000 - fv) << FRAC_BITS; div_den = W'(4000); end
         S_DIV_R:    begin div_num = W'(13'd4000 - rv) << FRAC_BITS; div_den = W'(4000); end
         S_MIX: begin
            mul_a = s_neg_ff ? ONE - s_mag_ff : ONE - s_mag_ff;
            mul_b = t_mag_ff;
         end
         S_SCALE_L1: begin mul_a = left_ff; mul_b = tilt_ff; end
         S_SCALE_L2: begin mul_a = left_ff; mul_b = (near_f_ff || near_r_ff) ? HALF : rear_ff; end
         S_SCALE_L3: begin mul_a = left_ff; mul_b = front_ff; end
         S_SCALE_R1: begin mul_a = right_ff; mul_b = tilt_ff; end
         S_SCALE_R2: begin mul_a = right_ff; mul_b = (near_f_ff || near_r_ff) ? HALF : rear_ff; end
         S_SCALE_R3: begin mul_a = right_ff; mul_b = front_ff; end
         default: ;
      endcase
   end

   logic go;
   assign go = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // result register free this cycle
   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   logic [W-1:0] mp_sh;
   assign mp_sh = mul_p >> FRAC_BITS;
   logic [W-1:0] duty_l, duty_r;
   assign duty_l = left_ff >> FRAC_BITS;
   assign duty_r = right_ff >> FRAC_BITS;

   // sequencer
   logic first_ff;
   assign div_start = first_ff && (state_ff == S_DIV_T || state_ff == S_DIV_S ||
      state_ff == S_DIV_TILT || state_ff == S_DIV_F || state_ff == S_DIV_R);
   assign mul_start = first_ff && (state_ff == S_MIX || state_ff == S_SCALE_L1 ||
      state_ff == S_SCALE_L2 || state_ff == S_SCALE_L3 || state_ff == S_SCALE_R1 ||
      state_ff == S_SCALE_R2 || state_ff == S_SCALE_R3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         center_ff    <= ssdm_pkg::JOY_CENTER_RST;
         tdz_ff       <= ssdm_pkg::THR_DZ_RST;
         sdz_ff       <= ssdm_pkg::STR_DZ_RST;
         dir_ff       <= 2'b00;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               ssdm_pkg::CSR_JOY_CENTER: center_ff <= csr_wdata[9:0];
               ssdm_pkg::CSR_THR_DZ:     tdz_ff <= csr_wdata;
               ssdm_pkg::CSR_STR_DZ:     sdz_ff <= csr_wdata;
               default: ;
            endcase
         end
         // result valid: set on a new result, cleared when taken
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         first_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (go) begin
               req_ff <= req_data;
               state_ff <= S_DIV_T;
               first_ff <= 1'b1;
            end
            S_DIV_T: if (div_done) begin
               t_mag_ff  <= dzt ? '0 : sat_t ? ONE : div_q;
               t_zero_ff <= dzt || mt == 10'd0;
               t_neg_ff  <= dt[10];
               state_ff  <= S_DIV_S;
               first_ff  <= 1'b1;
            end
            S_DIV_S: if (div_done) begin
               s_mag_ff  <= dzs ? '0 : sat_s ? ONE : div_q;
               s_zero_ff <= dzs || ms == 10'd0;
               s_neg_ff  <= !ds[10];
               state_ff  <= S_DIV_TILT;
               first_ff  <= 1'b1;
            end
            S_DIV_TILT: if (div_done) begin
               tilt_ff  <= (div_q <= FLOOR) ? FLOOR : div_q;
               state_ff <= S_DIV_F;
               first_ff <= 1'b1;
            end
            S_DIV_F: if (div_done) begin
               front_ff  <= (fv > 13'd2000) ? '0 : div_q;
               near_f_ff <= (fv > 13'd2000) || div_q < HALF;
               state_ff  <= S_DIV_R;
               first_ff  <= 1'b1;
            end
            S_DIV_R: if (div_done) begin
               rear_ff   <= (rv > 13'd2000) ? '0 : div_q;
               near_r_ff <= (rv > 13'd2000) || div_q < HALF;
               if (!t_zero_ff) dir_ff <= t_neg_ff ? 2'b00 : 2'b11;
               state_ff  <= S_MIX;
               first_ff  <= 1'b1;
            end
            S_MIX: if (mul_done) begin
               // pure throttle on both tracks, reduced inner track on a turn
               left_ff  <= t_mag_ff * W'(255);
               right_ff <= t_mag_ff * W'(255);
               if (!s_zero_ff) begin
                  if (s_neg_ff) right_ff <= mp_sh * W'(255);
                  else left_ff <= mp_sh * W'(255);
               end
               // spin in place
               if (t_zero_ff && !near_f_ff && !near_r_ff && !s_zero_ff) begin
                  left_ff  <= s_mag_ff * W'(255);
                  right_ff <= s_mag_ff * W'(255);
                  dir_ff   <= s_neg_ff ? 2'b01 : 2'b10;
               end
               if (near_f_ff) dir_ff <= 2'b00;
               else if (near_r_ff) dir_ff <= 2'b11;
               state_ff <= S_SCALE_L1;
               first_ff <= 1'b1;
            end
            S_SCALE_L1: if (mul_done) begin
               left_ff <= mp_sh; state_ff <= S_SCALE_L2; first_ff <= 1'b1;
            end
            S_SCALE_L2: if (mul_done) begin
               left_ff <= mp_sh; first_ff <= 1'b1;
               state_ff <= (near_f_ff || near_r_ff) ? S_SCALE_R1 : S_SCALE_L3;
            end
            S_SCALE_L3: if (mul_done) begin
               left_ff <= mp_sh; state_ff <= S_SCALE_R1; first_ff <= 1'b1;
            end
            S_SCALE_R1: if (mul_done) begin
               right_ff <= mp_sh; state_ff <= S_SCALE_R2; first_ff <= 1'b1;
            end
            S_SCALE_R2: if (mul_done) begin
               right_ff <= mp_sh;
               if (near_f_ff || near_r_ff) state_ff <= S_DONE;
               else begin state_ff <= S_SCALE_R3; first_ff <= 1'b1; end
            end
            S_SCALE_R3: if (mul_done) begin
               right_ff <= mp_sh; state_ff <= S_DONE;
            end
            S_DONE: if (rsp_free) begin
               rsp_ff.left_speed    <= (duty_l > W'(255)) ? 8'd255 : duty_l[7:0];
               rsp_ff.right_speed   <= (duty_r > W'(255)) ? 8'd255 : duty_r[7:0];
               rsp_ff.left_forward  <= dir_ff[0];
               rsp_ff.right_forward <= dir_ff[1];
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

/* tb/skid_steer_drive_mixer_core_tb.sv */
`timescale 1ns / 100ps

module skid_steer_drive_mixer_core_tb;

   localparam int FB = ssdm_pkg::FRAC_BITS_DEF;
   localparam longint UNIT = 64'sd1 << FB;
   localparam longint TILT_MIN = (4 * UNIT + 5) / 10;
   localparam int WALK_ITEMS = 1750;
   localparam int SETTLE_CYCLES = 8 * (FB + 28) + 20;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ssdm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ssdm_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [14:0] csr_wdata = '0;

   // mixer configuration and held direction bits as the predictor sees them
   logic [9:0]  mix_center;
   logic [14:0] mix_thr_dz;
   logic [14:0] mix_str_dz;
   logic [1:0]  mix_dirs;

   ssdm_pkg::rsp_type duty_queue[$];
   int error_count = 0;
   int duty_count = 0;
   int item_count = 0;
   bit rx_stall_on = 1'b1;

   skid_steer_drive_mixer_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // joystick axis shaping to a signed fraction
   function automatic longint shape_axis(logic [9:0] count, logic [14:0] dz, longint span);
      longint d, mag;
      d = longint'(count) - longint'(mix_center);
      mag = d < 0 ? -d : d;
      if (mag * UNIT < longint'(dz) * span) return 0;
      if (mag > span) return d < 0 ? -UNIT : UNIT;
      return (d * UNIT) / span;
   endfunction

   function automatic longint tilt_factor(logic [7:0] deg);
      longint a, f;
      a = longint'(deg);
      if (a > 90) a = 90;
      if (a <= 10) a = 0;
      f = ((90 - a) * UNIT) / 90;
      if (f <= TILT_MIN) f = TILT_MIN;
      return f;
   endfunction

   function automatic longint range_factor(logic [12:0] mv);
      longint v;
      v = longint'(mv);
      if (v < 500) v = 0;
      if (v > 2000) return 0;
      return ((4000 - v) * UNIT) / 4000;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> FB;
   endfunction

   function automatic logic [7:0] duty_of(longint v);
      longint q;
      q = v >>> FB;
      return q > 255 ? 8'd255 : q[7:0];
   endfunction

   // predicted track duties and directions for one joystick/sensor sample
   function automatic ssdm_pkg::rsp_type mix_tracks(ssdm_pkg::req_type r);
      longint t, s, tilt, front, rear, half, p, left, right, m;
      ssdm_pkg::rsp_type o;
      t = shape_axis(r.throttle_count, mix_thr_dz, 26);
      s = -shape_axis(r.steer_count, mix_str_dz, 25);
      tilt = tilt_factor(r.tilt_deg);
      front = range_factor(r.front_mv);
      rear = range_factor(r.rear_mv);
      half = UNIT / 2;
      if (t > 0) mix_dirs = 2'b11;
      else if (t < 0) mix_dirs = 2'b00;
      p = t < 0 ? -t : t;
      if (s < 0) begin
         right = qmul(UNIT + s, p) * 255;
         left = p * 255;
      end else if (s > 0) begin
         right = p * 255;
         left = qmul(UNIT - s, p) * 255;
      end else begin
         left = p * 255;
         right = p * 255;
      end
      // spin in place
      if (p == 0 && front >= half && rear >= half && s != 0) begin
         m = s < 0 ? -s : s;
         mix_dirs = s < 0 ? 2'b01 : 2'b10;
         left = m * 255;
         right = m * 255;
      end
      if (front < half || rear < half) begin
         mix_dirs = front < half ? 2'b00 : 2'b11;
         left = qmul(qmul(left, tilt), half);
         right = qmul(qmul(right, tilt), half);
      end else begin
         left = qmul(qmul(qmul(left, tilt), rear), front);
         right = qmul(qmul(qmul(right, tilt), rear), front);
      end
      o.left_speed = duty_of(left);
      o.right_speed = duty_of(right);
      o.left_forward = mix_dirs[0];
      o.right_forward = mix_dirs[1];
      return o;
   endfunction

   // send one transaction, with an optional typed-in expectation; valid stays up
   task automatic send_sample(ssdm_pkg::req_type r, bit has_fixed, ssdm_pkg::rsp_type fixed);
      ssdm_pkg::rsp_type p;
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = mix_tracks(r);
      if (has_fixed && p !== fixed) begin
         $error("fixed row disagrees with predictor: row %h predictor %h", fixed, p);
         error_count++;
      end
      duty_queue.push_back(has_fixed ? fixed : p);
      item_count++;
      @(negedge clock);
   endtask

   // drop valid and stay idle
   task automatic req_idle(int gap);
      req_valid <= 1'b0;
      repeat (gap + 1) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [14:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         ssdm_pkg::CSR_JOY_CENTER: mix_center = val[9:0];
         ssdm_pkg::CSR_THR_DZ:     mix_thr_dz = val;
         ssdm_pkg::CSR_STR_DZ:     mix_str_dz = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_results();
      while (duty_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [12:0] pick_mv();
      case ($urandom_range(0, 5))
         0: return 13'($urandom_range(0, 499));
         1: return 13'($urandom_range(500, 2000));
         2: return 13'($urandom_range(1900, 2100));
         3: return 13'($urandom_range(0, 8191));
         default: return 13'($urandom_range(0, 1300));
      endcase
   endfunction

   function automatic logic [9:0] pick_count();
      int c;
      if ($urandom_range(0, 3) == 0) return 10'($urandom);
      c = int'(mix_center) + $urandom_range(0, 70) - 35;
      if (c < 0) c = 0;
      if (c > 1023) c = 1023;
      return 10'(c);
   endfunction

   // result checker
   always @(posedge clock) begin
      ssdm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         duty_count++;
         if (duty_queue.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            error_count++;
         end else begin
            want = duty_queue.pop_front();
            if (rsp_data.left_speed !== want.left_speed) begin
               $error("left_speed expected %0d actual %0d", want.left_speed, rsp_data.left_speed);
               error_count++;
            end
            if (rsp_data.right_speed !== want.right_speed) begin
               $error("right_speed expected %0d actual %0d",
                      want.right_speed, rsp_data.right_speed);
               error_count++;
            end
            if (rsp_data.left_forward !== want.left_forward) begin
               $error("left_forward expected %0b actual %0b",
                      want.left_forward, rsp_data.left_forward);
               error_count++;
            end
            if (rsp_data.right_forward !== want.right_forward) begin
               $error("right_forward expected %0b actual %0b",
                      want.right_forward, rsp_data.right_forward);
               error_count++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (!rx_stall_on) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 9) < 6);
   end

   initial begin
      #50ms;
      $display("timeout waiting for results");
      $display("skid_steer_drive_mixer_core verification failed");
      $finish;
   end

   // directed rows: sample, whether a typed-in result applies, that result
   typedef struct {
      ssdm_pkg::req_type r;
      bit                fixed;
      ssdm_pkg::rsp_type o;
   } row_type;

   initial begin
      row_type rows[$];
      ssdm_pkg::req_type r;
      int burst;
      logic [14:0] dz_thr[4] = '{15'd0, 15'd2621, 15'd16384, 15'd32767};
      logic [14:0] dz_str[4] = '{15'd0, 15'd1638, 15'd20000, 15'd32767};
      logic [9:0]  centers[4] = '{10'd195, 10'd0, 10'd1023, 10'd512};

      mix_center = ssdm_pkg::JOY_CENTER_RST;
      mix_thr_dz = ssdm_pkg::THR_DZ_RST;
      mix_str_dz = ssdm_pkg::STR_DZ_RST;
      mix_dirs = 2'b00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // neutral, both sensors clear: zero duty, reset directions held
      rows.push_back('{'{10'd195, 10'd195, 8'd0, 13'd0, 13'd0}, 1, '{8'd0, 8'd0, 1'b0, 1'b0}});
      // full throttle clear, level: 255*ONE scaled by 1*1*1 = 255
      rows.push_back('{'{10'd1023, 10'd195, 8'd0, 13'd0, 13'd0}, 1, '{8'd255, 8'd255, 1'b1, 1'b1}});
      // full reverse with front near: reverse at half speed
      rows.push_back('{'{10'd0, 10'd195, 8'd0, 13'd5000, 13'd0}, 1, '{8'd127, 8'd127, 1'b0, 1'b0}});
      // rear near forces forward
      rows.push_back('{'{10'd0, 10'd195, 8'd0, 13'd0, 13'd8191}, 1, '{8'd127, 8'd127, 1'b1, 1'b1}});
      // zero throttle keeps held directions
      rows.push_back('{'{10'd195, 10'd195, 8'd0, 13'd1000, 13'd1000}, 0, '0});
      // spin in place both ways
      rows.push_back('{'{10'd195, 10'd0, 8'd0, 13'd0, 13'd0}, 1, '{8'd255, 8'd255, 1'b0, 1'b1}});
      rows.push_back('{'{10'd195, 10'd1023, 8'd0, 13'd0, 13'd0}, 1, '{8'd255, 8'd255, 1'b1, 1'b0}});
      rows.push_back('{'{10'd195, 10'd1023, 8'd255, 13'd1500, 13'd2000}, 0, '0});
      // tilt extremes and edges
      rows.push_back('{'{10'd1023, 10'd195, 8'd10, 13'd499, 13'd500}, 0, '0});
      rows.push_back('{'{10'd1023, 10'd195, 8'd11, 13'd2000, 13'd2001}, 0, '0});
      rows.push_back('{'{10'd1023, 10'd195, 8'd90, 13'd1999, 13'd499}, 0, '0});
      rows.push_back('{'{10'd1023, 10'd195, 8'd180, 13'd0, 13'd0}, 0, '0});
      // steering blends and deadzone edges
      rows.push_back('{'{10'd215, 10'd180, 8'd45, 13'd700, 13'd1200}, 0, '0});
      rows.push_back('{'{10'd199, 10'd192, 8'd30, 13'd100, 13'd100}, 0, '0});
      rows.push_back('{'{10'd200, 10'd198, 8'd60, 13'd600, 13'd600}, 0, '0});
      rows.push_back('{'{10'd221, 10'd220, 8'd20, 13'd0, 13'd0}, 0, '0});
      rows.push_back('{'{10'd169, 10'd170, 8'd0, 13'd1000, 13'd0}, 0, '0});
      rows.push_back('{'{10'd1023, 10'd1023, 8'd255, 13'd8191, 13'd8191}, 0, '0});

      foreach (rows[i]) send_sample(rows[i].r, rows[i].fixed, rows[i].o);
      req_idle(0);
      drain_results();

      // unknown index ignored, then register sweeps
      write_reg(CSR_UNUSED, 15'h7fff);
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_reg(ssdm_pkg::CSR_JOY_CENTER, {5'd0, centers[ph % 4]});
            write_reg(ssdm_pkg::CSR_THR_DZ, dz_thr[ph % 4]);
            write_reg(ssdm_pkg::CSR_STR_DZ, dz_str[(ph + 1) % 4]);
         end
         rx_stall_on = (ph != 2);
         while (item_count < rows.size() + (ph + 1) * (WALK_ITEMS / 6)) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               r.throttle_count = pick_count();
               r.steer_count = pick_count();
               r.tilt_deg = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 95));
               r.front_mv = pick_mv();
               r.rear_mv = pick_mv();
               send_sample(r, 0, '0);
            end
            if (ph != 3) req_idle($urandom_range(0, 6));
         end
         req_idle(0);
         drain_results();
      end

      $display("covered %0d samples and %0d results over six register settings",
               item_count, duty_count);
      if (error_count == 0)
         $display("skid_steer_drive_mixer_core verification clean");
      else
         $display("skid_steer_drive_mixer_core verification failed");
      $finish;
   end

endmodule
